/* design/qdec_pkg.sv */
// shared types, constants and the gray step table for the quadrature decoder
package qdec_pkg;

  // default number of encoder channels
  localparam int NUM_CHANNELS_DEF = 2;
  // widths of the sample and result fields
  localparam int SAMPLE_W = 8;
  localparam int CHAN_W   = 2;
  localparam int PHASE_W  = 2;
  // bit position of the low phase bit of channel zero
  localparam int PHASE_BASE = 6;

  // step direction given by a phase transition
  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_CW   = 2'b01,
    DIR_CCW  = 2'b10
  } dir_t;

  // per-lane finding handed to the merge stage
  typedef struct packed {
    logic step;
    logic cw;
  } lane_evt_t;

  // transition table indexed by old phase and new phase
  localparam dir_t STEP_TABLE [16] = '{
    DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE,
    DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
    DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
    DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE
  };

  function automatic dir_t step_dir(input logic [PHASE_W-1:0] prev,
                                    input logic [PHASE_W-1:0] now);
    return STEP_TABLE[{prev, now}];
  endfunction

endpackage

/* design/multi_channel_quadrature_decoder.sv */
// top level of the multi-channel quadrature decoder
// Each accepted sample byte carries two phase bits per encoder channel, channel e at
// bits 7-2e and 6-2e. All channels are decoded side by side, combinationally, against
// their stored phases; the first sample after reset only loads the phases. Step
// events leave one per cycle while out_ready is high, in ascending channel order,
// the final one of a sample flagged by last, and a double step yields no event. A
// sample's events leave one after another through the single output port. The next
// sample is taken in the cycle its predecessor's last event leaves, so back-to-back
// samples flow without gaps.
module multi_channel_quadrature_decoder #(
  parameter int NUM_CHANNELS = qdec_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qdec_pkg::SAMPLE_W-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qdec_pkg::CHAN_W-1:0]   channel,
  output logic                          clockwise,
  output logic                          last
);
  import qdec_pkg::*;

  logic      primed;
  logic      load;
  lane_evt_t evt [NUM_CHANNELS];

  assign load = in_valid && in_ready;

  // first sample only primes the phases
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (load) begin
      primed <= 1'b1;
    end
  end

  // one lane per encoder channel
  for (genvar e = 0; e < NUM_CHANNELS; e++) begin : g_lane
    qdec_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ph     (sample[PHASE_BASE - PHASE_W * e +: PHASE_W]),
      .load   (load),
      .primed (primed),
      .evt    (evt[e])
    );
  end

  // serialize lane events onto the output
  qdec_merge #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .load          (load),
    .empty_next_ok (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel       (channel),
    .clockwise     (clockwise),
    .last          (last)
  );

endmodule

/* design/qdec_lane.sv */
// one decoder lane: stored phase of a channel and its step detection
module qdec_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [qdec_pkg::PHASE_W-1:0]  ph,
  input  logic                          load,
  input  logic                          primed,
  output qdec_pkg::lane_evt_t           evt
);
  import qdec_pkg::*;

  logic [PHASE_W-1:0] phase;
  dir_t               dir;

  // look up the transition from the stored phase
  always_comb begin
    dir      = step_dir(phase, ph);
    evt.step = primed && (dir != DIR_NONE);
    evt.cw   = (dir == DIR_CW);
  end

  // stored phase always follows an accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (load) begin
      phase <= ph;
    end
  end

endmodule

/* design/qdec_merge.sv */
// merge stage: holds pending lane events and sends them out lowest channel first
module qdec_merge #(
  parameter int NUM_CHANNELS = qdec_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qdec_pkg::lane_evt_t           evt [NUM_CHANNELS],
  input  logic                          load,
  output logic                          empty_next_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qdec_pkg::CHAN_W-1:0]   channel,
  output logic                          clockwise,
  output logic                          last
);
  import qdec_pkg::*;

  logic [NUM_CHANNELS-1:0] pend;
  logic [NUM_CHANNELS-1:0] pend_next;
  logic [NUM_CHANNELS-1:0] cw;
  logic [NUM_CHANNELS-1:0] rest;
  logic [NUM_CHANNELS-1:0] new_pend;
  logic [NUM_CHANNELS-1:0] new_cw;

  // unpack lane findings
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      new_pend[i] = evt[i].step;
      new_cw[i]   = evt[i].cw;
    end
  end

  // pick the lowest pending channel
  always_comb begin
    channel   = '0;
    clockwise = 1'b0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        channel   = CHAN_W'(i);
        clockwise = cw[i];
      end
    end
    rest      = pend & (pend - NUM_CHANNELS'(1));
    last      = (rest == '0);
    out_valid = |pend;
    // a new request fits when nothing is pending or the pending set drains this cycle
    empty_next_ok = !out_valid || (out_ready && last);
  end

  // next pending set
  always_comb begin
    if (load) begin
      pend_next = new_pend;
    end else if (out_valid && out_ready) begin
      pend_next = rest;
    end else begin
      pend_next = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // direction bits captured with the pending set
  always_ff @(posedge clk) begin
    if (load) begin
      cw <= new_cw;
    end
  end

endmodule

/* sim/multi_channel_quadrature_decoder_tb.sv */
`timescale 1ns / 100ps
// testbench for the multi-channel quadrature decoder: gray walks, double steps and stalls
module multi_channel_quadrature_decoder_tb;
  import qdec_pkg::*;

  localparam int NUM_CH = NUM_CHANNELS_DEF;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int NUM_DIRECTED = 17;

  // hand-picked samples: priming, unused bits, gray walks both ways, double steps
  localparam logic [SAMPLE_W-1:0] DIRECTED_SAMPLES [NUM_DIRECTED] = '{
    8'hB5, 8'hBA, 8'hF0, 8'h7F, 8'h3C, 8'h13, 8'h40, 8'hD0, 8'hB0,
    8'h20, 8'hDF, 8'h9F, 8'h70, 8'hFF, 8'h00, 8'h0F, 8'hF0
  };

  typedef struct {
    logic [CHAN_W-1:0] chan;
    logic              cw;
    logic              fin;
  } step_evt_t;

  typedef enum {ST_DIRECTED, ST_WALK, ST_STEADY, ST_PRESSURE, ST_NOISE} stage_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAN_W-1:0]   channel;
  logic                clockwise;
  logic                last;

  // samples waiting to be offered and step events still owed by the block
  logic [SAMPLE_W-1:0] pending [$];
  step_evt_t           steps_due [$];

  stage_t stage     = ST_DIRECTED;
  bit     gaps_on   = 1'b1;
  bit     stalls_on = 1'b1;

  // predictor state
  logic [PHASE_W-1:0] tracked_phase [NUM_CH];
  bit                 tracked_primed;
  // stimulus generator state, one phase per bit pair of the sample
  logic [PHASE_W-1:0] gen_phase [4];

  int errors, samples_taken, steps_checked, cw_steps, ccw_steps, double_steps;
  int gap_left, stall_left;
  bit pressure_done;

  multi_channel_quadrature_decoder #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .channel(channel),
    .clockwise(clockwise),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // neighbor of a phase one gray step away in the given direction
  function automatic logic [PHASE_W-1:0] gray_next(logic [PHASE_W-1:0] ph, bit cw);
    case (ph)
      2'b00: return cw ? 2'b10 : 2'b01;
      2'b10: return cw ? 2'b11 : 2'b00;
      2'b11: return cw ? 2'b01 : 2'b10;
      default: return cw ? 2'b00 : 2'b11;
    endcase
  endfunction

  function automatic dir_t transition_dir(logic [PHASE_W-1:0] was, logic [PHASE_W-1:0] now);
    if (now == gray_next(was, 1'b1)) return DIR_CW;
    if (now == gray_next(was, 1'b0)) return DIR_CCW;
    return DIR_NONE;
  endfunction

  // decode one sample against the tracked phases and queue the step events
  function automatic void predict_steps(logic [SAMPLE_W-1:0] s);
    dir_t               dirs [NUM_CH];
    logic [PHASE_W-1:0] now;
    step_evt_t          ev;
    int                 final_ch;
    final_ch = -1;
    if (!tracked_primed) begin
      for (int e = 0; e < NUM_CH; e++) tracked_phase[e] = s[PHASE_BASE-2*e +: PHASE_W];
      tracked_primed = 1'b1;
      return;
    end
    for (int e = 0; e < NUM_CH; e++) begin
      now = s[PHASE_BASE-2*e +: PHASE_W];
      dirs[e] = DIR_NONE;
      if (now != tracked_phase[e]) begin
        dirs[e] = transition_dir(tracked_phase[e], now);
        if (dirs[e] == DIR_NONE) double_steps++;
        else final_ch = e;
        tracked_phase[e] = now;
      end
    end
    for (int e = 0; e < NUM_CH; e++) begin
      if (dirs[e] != DIR_NONE) begin
        ev.chan = CHAN_W'(e);
        ev.cw   = (dirs[e] == DIR_CW);
        ev.fin  = (e == final_ch);
        steps_due.push_back(ev);
      end
    end
  endfunction

  // mostly legal gray moves per channel, with some fully random bytes mixed in
  function automatic logic [SAMPLE_W-1:0] next_sample(int noise_pct);
    logic [SAMPLE_W-1:0] s;
    int                  r;
    if ($urandom_range(0, 99) < noise_pct) begin
      s = SAMPLE_W'($urandom);
      for (int e = 0; e < 4; e++) gen_phase[e] = s[PHASE_BASE-2*e +: PHASE_W];
      return s;
    end
    for (int e = 0; e < 4; e++) begin
      r = $urandom_range(0, 99);
      if (r >= 35 && r < 65) gen_phase[e] = gray_next(gen_phase[e], 1'b1);
      else if (r >= 65 && r < 92) gen_phase[e] = gray_next(gen_phase[e], 1'b0);
      else if (r >= 92) gen_phase[e] = gen_phase[e] ^ 2'b11;
      s[PHASE_BASE-2*e +: PHASE_W] = gen_phase[e];
    end
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // request driver: offers the head of the pending queue, with random idle gaps between requests
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sample   <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) void'(pending.pop_front());
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending.size() > 0) begin
          in_valid <= 1'b1;
          sample   <= pending[0];
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output pacing, including one long hold-off while requests keep coming
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stage == ST_PRESSURE && !pressure_done) begin
      pressure_done = 1'b1;
      stall_left = HOLD_OFF_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (!stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready <= 1'b1;
      end else if (r < 93) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(5, 40);
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted step event
  always @(posedge clk) begin
    step_evt_t want;
    if (rst) begin
      tracked_primed = 1'b0;
      for (int e = 0; e < NUM_CH; e++) tracked_phase[e] = '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_steps(sample);
        samples_taken++;
      end
      if (out_valid && out_ready) begin
        if (steps_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected step event, channel %0d clockwise %0b last %0b",
                   $time, channel, clockwise, last);
        end else begin
          want = steps_due.pop_front();
          steps_checked++;
          if (want.cw) cw_steps++;
          else ccw_steps++;
          if (channel !== want.chan) begin
            errors++;
            $display("%0t: channel expected %0d actual %0d", $time, want.chan, channel);
          end
          if (clockwise !== want.cw) begin
            errors++;
            $display("%0t: clockwise expected %0b actual %0b", $time, want.cw, clockwise);
          end
          if (last !== want.fin) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.fin, last);
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending.size() != 0 || steps_due.size() != 0) @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walks and corner cases
    foreach (DIRECTED_SAMPLES[i]) pending.push_back(DIRECTED_SAMPLES[i]);
    for (int e = 0; e < 4; e++)
      gen_phase[e] = DIRECTED_SAMPLES[NUM_DIRECTED-1][PHASE_BASE-2*e +: PHASE_W];
    drain();

    // random gray walks with random idling on both sides
    stage = ST_WALK;
    repeat (80) pending.push_back(next_sample(5));
    drain();

    // back to back, no idling anywhere
    stage     = ST_STEADY;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (40) pending.push_back(next_sample(5));
    drain();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // long output hold-off so the block backs up into its input
    stage = ST_PRESSURE;
    repeat (40) pending.push_back(next_sample(5));
    drain();

    // heavier share of arbitrary bytes
    stage = ST_NOISE;
    repeat (40) pending.push_back(next_sample(40));
    drain();

    repeat (20) @(posedge clk);
    $display("decoded %0d samples: %0d step events checked (%0d cw, %0d ccw), %0d double steps",
             samples_taken, steps_checked, cw_steps, ccw_steps, double_steps);
    $display("covered priming, ignored bits, back-to-back flow and a %0d-cycle output hold-off",
             HOLD_OFF_CYCLES);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
